// ===== design/scu_pkg.sv =====
// ----------------------------------------------------------------------------
// scu_pkg
// Shared types, float constants and single-precision arithmetic helpers.
// ----------------------------------------------------------------------------
package scu_pkg;

  localparam int PIPE_DEPTH  = 17;
  localparam int FRONT_DEPTH = 7;

  localparam logic [31:0] QNAN        = 32'h7FC0_0000;
  localparam logic [31:0] F_ZERO      = 32'h0000_0000;
  localparam logic [31:0] F_ONE       = 32'h3F80_0000;
  localparam logic [31:0] F_MINUS_ONE = 32'hBF80_0000;
  localparam logic [31:0] F_HALF      = 32'h3F00_0000;
  localparam logic [31:0] F_MHALF     = 32'hBF00_0000;
  localparam logic [31:0] INV_PIO2    = 32'h3F22_F983;
  localparam logic [31:0] PIO2_A      = 32'h3FC9_0FDA;
  localparam logic [31:0] PIO2_B      = 32'h33A2_2168;
  localparam logic [31:0] PIO2_C      = 32'h27C2_34C4;
  localparam logic [31:0] K_S1        = 32'hBE2A_AAA3;
  localparam logic [31:0] K_S2        = 32'h3C08_839E;
  localparam logic [31:0] K_S3        = 32'hB94C_A1F9;
  localparam logic [31:0] K_C1        = 32'h3D2A_AAA5;
  localparam logic [31:0] K_C2        = 32'hBAB6_061A;
  localparam logic [31:0] K_C3        = 32'h37CC_F5CE;

  localparam logic OP_SIN = 1'b0;
  localparam logic OP_COS = 1'b1;

  typedef struct packed {
    logic       op;
    logic [1:0] quad;
    logic       oor;
  } meta_t;

  function automatic logic [6:0] clz64(input logic [63:0] m);
    logic [6:0] cnt;
    cnt = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) cnt = 7'(63 - i);
    end
    return cnt;
  endfunction

  // value = m * 2^e, rounded to nearest even, subnormals kept
  function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
                                             input logic [63:0] m);
    logic [6:0]          lz;
    logic [63:0]         mn;
    logic signed [11:0]  ee;
    logic [11:0]         sh;
    logic [127:0]        wide;
    logic [23:0]         keep;
    logic                g;
    logic                st;
    logic [7:0]          eb;
    logic                inc;
    logic [31:0]         res;
    lz = clz64(m);
    mn = m << lz;
    ee = e + 12'sd190 - $signed({5'b0, lz});
    keep = '0;
    g = 1'b0;
    st = 1'b0;
    eb = '0;
    wide = '0;
    sh = '0;
    if (m == '0) return {s, 31'b0};
    if (ee >= 12'sd255) return {s, 8'hFF, 23'b0};
    if (ee >= 12'sd1) begin
      keep = mn[63:40];
      g = mn[39];
      st = |mn[38:0];
      eb = 8'(ee - 12'sd1);
    end else begin
      sh = 12'(12'sd1 - ee);
      if (sh >= 12'd64) begin
        st = 1'b1;
      end else begin
        wide = {mn, 64'b0} >> sh[5:0];
        keep = wide[127:104];
        g = wide[103];
        st = |wide[102:0];
      end
    end
    inc = g & (st | keep[0]);
    res = {1'b0, eb, 23'b0} + {8'b0, keep} + {31'b0, inc};
    return {s, res[30:0]};
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic              s;
    logic              a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0]       sa, sb;
    logic [11:0]       ea, eb;
    logic [47:0]       prod;
    logic signed [11:0] e;
    s = a[31] ^ b[31];
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    a_zero = a[30:0] == '0;
    b_zero = b[30:0] == '0;
    sa = {a[30:23] != '0, a[22:0]};
    sb = {b[30:23] != '0, b[22:0]};
    ea = (a[30:23] == '0) ? 12'd1 : {4'b0, a[30:23]};
    eb = (b[30:23] == '0) ? 12'd1 : {4'b0, b[30:23]};
    prod = {24'b0, sa} * {24'b0, sb};
    e = $signed(ea + eb - 12'd300);
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) return QNAN;
    if (a_inf || b_inf) return {s, 8'hFF, 23'b0};
    if (a_zero || b_zero) return {s, 31'b0};
    return round_pack(s, e, {16'b0, prod});
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]        x, y;
    logic               a_nan, b_nan, a_inf, b_inf;
    logic [23:0]        sx, sy;
    logic [11:0]        ex, ey;
    logic [11:0]        d;
    logic [52:0]        mx, my;
    logic [105:0]       shw;
    logic [63:0]        m;
    logic signed [11:0] e;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    if (a[30:0] >= b[30:0]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    sx = {x[30:23] != '0, x[22:0]};
    sy = {y[30:23] != '0, y[22:0]};
    ex = (x[30:23] == '0) ? 12'd1 : {4'b0, x[30:23]};
    ey = (y[30:23] == '0) ? 12'd1 : {4'b0, y[30:23]};
    d = ex - ey;
    mx = {sx, 29'b0};
    shw = '0;
    if (d >= 12'd53) begin
      my = {52'b0, sy != '0};
    end else begin
      shw = {sy, 29'b0, 53'b0} >> d[5:0];
      my = shw[105:53] | {52'b0, |shw[52:0]};
    end
    m = (x[31] ^ y[31]) ? ({11'b0, mx} - {11'b0, my}) : ({11'b0, mx} + {11'b0, my});
    e = $signed(ex - 12'd179);
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) return QNAN;
    if (a_inf) return a;
    if (b_inf) return b;
    if (m == '0) return {x[31] & y[31], 31'b0};
    return round_pack(x[31], e, m);
  endfunction

endpackage

// ===== design/scu_pipe_ctl.sv =====
// ----------------------------------------------------------------------------
// scu_pipe_ctl
// Valid bits and per-stage load enables for the elastic pipeline.
// ----------------------------------------------------------------------------
module scu_pipe_ctl
  import scu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [PIPE_DEPTH-1:0] en
);

  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] rdy;

  // a stage loads when empty or when its successor loads
  always_comb begin
    rdy[PIPE_DEPTH-1] = !vld[PIPE_DEPTH-1] || m_tready;
    for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign en       = rdy;
  assign s_tready = rdy[0];
  assign m_tvalid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= s_tvalid;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        if (rdy[i]) vld[i] <= vld[i-1];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_empty_tail_flows: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready) else $error("pipe blocked with empty tail");

  a_sink_ready_flows: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready) else $error("pipe blocked while sink ready");

  a_fill_count: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !(m_tvalid && m_tready))
      |=> $countones(vld) == $past($countones(vld)) + 1)
    else $error("transaction lost or duplicated in pipe");
`endif

endmodule

// ===== design/scu_front.sv =====
// ----------------------------------------------------------------------------
// scu_front
// Stages 1-7: scale by 2/pi, round to n, quadrant, three-part reduction.
// ----------------------------------------------------------------------------
module scu_front
  import scu_pkg::*;
(
  input  logic                   clk,
  input  logic [FRONT_DEPTH-1:0] en,
  input  logic                   op,
  input  logic [31:0]            x_bits,
  output logic [31:0]            r_out,
  output meta_t                  meta_out
);

  logic [31:0] x1, f1;
  logic        op1;
  logic [31:0] x2, t2;
  logic        op2;
  logic [31:0] x3, fn3;
  meta_t       m3, m4, m5, m6, m7;
  logic [31:0] x4, p1_4, p2_4, p3_4;
  logic [31:0] r5, p2_5, p3_5;
  logic [31:0] r6, p3_6;
  logic [31:0] r7;

  logic [31:0] bias;
  logic [31:0] fn_c;
  logic [1:0]  quad_c;
  logic        oor_c;
  logic [7:0]  te;
  logic [23:0] tsig;
  logic [22:0] frac_mask;
  logic [23:0] shifted;
  logic [1:0]  low2;

  assign bias = (f1[31] && (f1[30:0] != '0) && !((f1[30:23] == 8'hFF) && (f1[22:0] != '0)))
              ? F_MHALF : F_HALF;

  // truncate t toward zero and take n mod 4
  always_comb begin
    te        = t2[30:23];
    tsig      = {1'b1, t2[22:0]};
    oor_c     = !((te < 8'd158) || (t2 == 32'hCF00_0000));
    frac_mask = '0;
    shifted   = '0;
    low2      = '0;
    if (te < 8'd127) begin
      fn_c = F_ZERO;
    end else if (te >= 8'd150) begin
      fn_c = t2;
    end else begin
      frac_mask = 23'h7F_FFFF >> (te - 8'd127);
      fn_c      = {t2[31:23], t2[22:0] & ~frac_mask};
    end
    if (te >= 8'd127 && te <= 8'd150) begin
      shifted = tsig >> (8'd150 - te);
      low2    = shifted[1:0];
    end else if (te == 8'd151) begin
      low2 = {tsig[0], 1'b0};
    end
    quad_c = t2[31] ? 2'(~low2 + 2'd1) : low2;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x1  <= x_bits;
      op1 <= op;
      f1  <= fmul(x_bits, INV_PIO2);
    end
    if (en[1]) begin
      x2  <= x1;
      op2 <= op1;
      t2  <= fadd(f1, bias);
    end
    if (en[2]) begin
      x3  <= x2;
      fn3 <= fn_c;
      m3  <= '{op: op2, quad: quad_c, oor: oor_c};
    end
    if (en[3]) begin
      x4   <= x3;
      m4   <= m3;
      p1_4 <= fmul(fn3, PIO2_A);
      p2_4 <= fmul(fn3, PIO2_B);
      p3_4 <= fmul(fn3, PIO2_C);
    end
    if (en[4]) begin
      m5   <= m4;
      r5   <= fadd(x4, {~p1_4[31], p1_4[30:0]});
      p2_5 <= p2_4;
      p3_5 <= p3_4;
    end
    if (en[5]) begin
      m6   <= m5;
      r6   <= fadd(r5, {~p2_5[31], p2_5[30:0]});
      p3_6 <= p3_5;
    end
    if (en[6]) begin
      m7 <= m6;
      r7 <= fadd(r6, {~p3_6[31], p3_6[30:0]});
    end
  end

  assign r_out    = r7;
  assign meta_out = m7;

endmodule

// ===== design/scu_back.sv =====
// ----------------------------------------------------------------------------
// scu_back
// Stages 8-17: sine and cosine polynomials, quadrant select and sign.
// ----------------------------------------------------------------------------
module scu_back
  import scu_pkg::*;
(
  input  logic                              clk,
  input  logic [PIPE_DEPTH-FRONT_DEPTH-1:0] en,
  input  logic [31:0]                       r_in,
  input  meta_t                             meta_in,
  output logic [31:0]                       y_bits,
  output logic                              out_of_range
);

  meta_t       m8, m9, m10, m11, m12, m13, m14, m15, m16;
  logic [31:0] r8, r2_8;
  logic [31:0] r9, r2_9, ts9, u9, a9, tc9, w9;
  logic [31:0] r10, r2_10, ts10, u10, a10, tc10, w10;
  logic [31:0] r11, ts11, u11, a11, tc11, w11;
  logic [31:0] r12, ts12, u12, a12, tc12, w12;
  logic [31:0] r13, u13, a13, w13;
  logic [31:0] sp14, cp14;
  logic [31:0] p15, q15;
  logic [31:0] v16;
  logic [31:0] y17;
  logic        oor17;

  logic [31:0] pick_a, pick_b;
  logic        neg;

  assign pick_a = (m14.op == OP_SIN) ? cp14 : sp14;
  assign pick_b = (m14.op == OP_SIN) ? sp14 : cp14;
  assign neg    = (m16.op == OP_SIN) ? m16.quad[1] : (m16.quad[1] ^ m16.quad[0]);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m8   <= meta_in;
      r8   <= r_in;
      r2_8 <= fmul(r_in, r_in);
    end
    if (en[1]) begin
      m9   <= m8;
      r9   <= r8;
      r2_9 <= r2_8;
      ts9  <= fmul(r2_8, K_S3);
      u9   <= fmul(r8, r2_8);
      a9   <= fmul(F_HALF, r2_8);
      tc9  <= fmul(r2_8, K_C3);
      w9   <= fmul(r2_8, r2_8);
    end
    if (en[2]) begin
      m10   <= m9;
      r10   <= r9;
      r2_10 <= r2_9;
      ts10  <= fadd(K_S2, ts9);
      u10   <= u9;
      a10   <= fadd(F_ONE, {~a9[31], a9[30:0]});
      tc10  <= fadd(K_C2, tc9);
      w10   <= w9;
    end
    if (en[3]) begin
      m11  <= m10;
      r11  <= r10;
      ts11 <= fmul(r2_10, ts10);
      u11  <= u10;
      a11  <= a10;
      tc11 <= fmul(r2_10, tc10);
      w11  <= w10;
    end
    if (en[4]) begin
      m12  <= m11;
      r12  <= r11;
      ts12 <= fadd(K_S1, ts11);
      u12  <= u11;
      a12  <= a11;
      tc12 <= fadd(K_C1, tc11);
      w12  <= w11;
    end
    if (en[5]) begin
      m13 <= m12;
      r13 <= r12;
      u13 <= fmul(u12, ts12);
      a13 <= a12;
      w13 <= fmul(w12, tc12);
    end
    if (en[6]) begin
      m14  <= m13;
      sp14 <= fadd(r13, u13);
      cp14 <= fadd(a13, w13);
    end
    if (en[7]) begin
      m15 <= m14;
      p15 <= fmul(pick_a, m14.quad[0] ? F_ONE : F_ZERO);
      q15 <= fmul(pick_b, m14.quad[0] ? F_ZERO : F_ONE);
    end
    if (en[8]) begin
      m16 <= m15;
      v16 <= fadd(p15, q15);
    end
    if (en[9]) begin
      oor17 <= m16.oor;
      y17   <= m16.oor ? QNAN : fmul(v16, neg ? F_MINUS_ONE : F_ONE);
    end
  end

  assign y_bits       = y17;
  assign out_of_range = oor17;

endmodule

// ===== design/float_sine_cosine_unit_core.sv =====
// ----------------------------------------------------------------------------
// float_sine_cosine_unit_core
// Single-precision sine/cosine with Cody-Waite reduction, 17-stage pipeline.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                 | tuser
//  s_*     | in  | [31:0] x_bits         | [0] op (0 sine, 1 cosine)
//  m_*     | out | [31:0] y_bits         | [0] out_of_range
//
//  One transaction per cycle is sustained while m_tready is high. Depth is
//  set by the chain of dependent float ops (at most one multiply or add in
//  series per stage). Reset clears only the valid bits. Each stage holds on
//  its own, so a stall fills bubbles before it stops the input.
// ----------------------------------------------------------------------------
module float_sine_cosine_unit_core
  import scu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] x_bits
  input  logic [0:0]  s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] y_bits
  output logic [0:0]  m_tuser    // [0] out_of_range
);

  logic [PIPE_DEPTH-1:0] en;
  logic [31:0]           r_mid;
  meta_t                 meta_mid;

  // Valid tracking and per-stage load enables
  scu_pipe_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .en       (en)
  );

  // Argument reduction: r = x - n*pi/2, quadrant = n mod 4
  scu_front u_front (
    .clk      (clk),
    .en       (en[FRONT_DEPTH-1:0]),
    .op       (s_tuser[0]),
    .x_bits   (s_tdata),
    .r_out    (r_mid),
    .meta_out (meta_mid)
  );

  // Polynomials, quadrant select and sign; NaN substitution on overflow
  scu_back u_back (
    .clk          (clk),
    .en           (en[PIPE_DEPTH-1:FRONT_DEPTH]),
    .r_in         (r_mid),
    .meta_in      (meta_mid),
    .y_bits       (m_tdata),
    .out_of_range (m_tuser[0])
  );

endmodule
